// ----- hw/rtl/pprd_pkg.sv -----
// ----------------------------------------------------------------------------
// pprd_pkg
// Shared constants for the point projection pipeline: register map,
// register reset values, saturation limits and pipeline depth.
// ----------------------------------------------------------------------------
package pprd_pkg;

   // pipeline depth from accepted request to result strobe
   localparam int unsigned PIPE_DEPTH = 38;
   // quotient bits of the normalising divider, one per stage
   localparam int unsigned DIV_STEPS  = 24;

   // register map (8-byte stride)
   localparam logic [2:0] REG_ROT0 = 3'd0;
   localparam logic [2:0] REG_ROT1 = 3'd1;
   localparam logic [2:0] REG_ROT2 = 3'd2;
   localparam logic [2:0] REG_TXY  = 3'd3;
   localparam logic [2:0] REG_TZD  = 3'd4;
   localparam logic [2:0] REG_INTR = 3'd5;

   // identity rotation after reset
   localparam logic [53:0] ROT0_RESET = 54'd65536;
   localparam logic [53:0] ROT1_RESET = 54'd17179869184;
   localparam logic [53:0] ROT2_RESET = 54'd4503599627370496;

   // saturation limits
   localparam logic [23:0]        NORM_LIMIT = 24'hFFFFFF;
   localparam logic signed [46:0] PIX_MAX    = 47'sd262143;
   localparam logic signed [46:0] PIX_MIN    = -47'sd262144;

   typedef logic signed [43:0] cam_type;
   typedef logic [23:0]        norm_type;

endpackage

// ----- hw/rtl/point_projection_radial_distortion.sv -----
// ----------------------------------------------------------------------------
// point_projection_radial_distortion
// Pinhole projection of world points with radial distortion k1/k2: rigid
// transform, divide by depth, radial correction, focal scale and offset.
// ----------------------------------------------------------------------------
// result: the result strobe is the last pipeline valid bit, and the pixels and
//   validity flag are registered so that they line up with it
// throughput: one request per clock outside reset, set by the fully pipelined
//   datapath (24 single-bit divider stages)
// reset: clears all pipeline valid bits and loads register defaults;
//   busy is high only while reset is asserted, results cannot be stalled
module point_projection_radial_distortion (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_world_x,
   input  logic signed [23:0] req_world_y,
   input  logic signed [23:0] req_world_z,
   output logic               rsp_strobe,
   output logic signed [18:0] rsp_pixel_u,
   output logic signed [18:0] rsp_pixel_v,
   output logic               rsp_valid_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   // configuration registers
   logic [53:0] rot_ff [3];
   logic [47:0] txy_ff;
   logic [55:0] tzd_ff;
   logic [63:0] intr_ff;
   logic        cfg_wr;

   // pipeline valid bits
   logic [pprd_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic                            accept;

   // decoded configuration
   logic signed [17:0] rot_c [3][3];
   logic signed [23:0] t_c [3];
   logic signed [23:0] w_c [3];
   logic signed [15:0] k1_c;
   logic signed [15:0] k2_c;
   logic [15:0]        f_c [2];
   logic [15:0]        c_c [2];

   // transform stages
   logic signed [41:0] prod_ff [3][3];
   pprd_pkg::cam_type  sa_ff [3];
   pprd_pkg::cam_type  sb_ff [3];
   pprd_pkg::cam_type  pc_ff [3];

   // divider set-up
   logic [60:0] num_ff [2];
   logic [42:0] den4_ff;
   logic        ok4_ff;
   logic        sg4_ff [2];
   logic [60:0] num_in [2];
   logic [43:0] mag_in [2];

   // divider stages
   logic [60:0] rem_ff [2][pprd_pkg::DIV_STEPS+1];
   logic [23:0] q_ff   [2][pprd_pkg::DIV_STEPS+1];
   logic        sat_ff [2][pprd_pkg::DIV_STEPS+1];
   logic        sgd_ff [2][pprd_pkg::DIV_STEPS+1];
   logic [42:0] dd_ff  [pprd_pkg::DIV_STEPS+1];
   logic        okd_ff [pprd_pkg::DIV_STEPS+1];
   logic [60:0] rem_in [2][pprd_pkg::DIV_STEPS+1];
   logic [23:0] q_in   [2][pprd_pkg::DIV_STEPS+1];

   // distortion and pixel stages
   pprd_pkg::norm_type xm_in [2];
   pprd_pkg::norm_type xmm_ff [2][5];
   logic               sgm_ff [2][5];
   logic               okm_ff [8];
   logic [47:0]        sq_ff [2];
   logic [48:0]        r2sum;
   logic [23:0]        r2_ff;
   logic [47:0]        r2sq;
   logic [31:0]        r4_ff;
   logic signed [40:0] k1r2_ff;
   logic signed [40:0] k1r2b_ff;
   logic signed [48:0] k2r4_ff;
   logic signed [50:0] csum;
   logic [50:0]        cmag;
   logic [35:0]        cm_ff;
   logic               csg_ff;
   logic [41:0]        pl_ff [2];
   logic [41:0]        ph_ff [2];
   logic               dsg_ff [2][3];
   logic [60:0]        dsum [2];
   logic [44:0]        dm_ff [2];
   logic [60:0]        fp_ff [2];
   logic [44:0]        pm [2];
   logic signed [46:0] ps [2];
   logic signed [46:0] pcl [2];

   // output registers
   logic signed [18:0] pix_ff [2];
   logic               valid_res_ff;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= pprd_pkg::ROT0_RESET;
         rot_ff[1] <= pprd_pkg::ROT1_RESET;
         rot_ff[2] <= pprd_pkg::ROT2_RESET;
         txy_ff    <= '0;
         tzd_ff    <= '0;
         intr_ff   <= '0;
      end else if (cfg_wr) begin
         case (paddr[5:3])
            pprd_pkg::REG_ROT0: rot_ff[0] <= pwdata[53:0];
            pprd_pkg::REG_ROT1: rot_ff[1] <= pwdata[53:0];
            pprd_pkg::REG_ROT2: rot_ff[2] <= pwdata[53:0];
            pprd_pkg::REG_TXY:  txy_ff    <= pwdata[47:0];
            pprd_pkg::REG_TZD:  tzd_ff    <= pwdata[55:0];
            pprd_pkg::REG_INTR: intr_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (paddr[5:3])
         pprd_pkg::REG_ROT0: prdata = {10'b0, rot_ff[0]};
         pprd_pkg::REG_ROT1: prdata = {10'b0, rot_ff[1]};
         pprd_pkg::REG_ROT2: prdata = {10'b0, rot_ff[2]};
         pprd_pkg::REG_TXY:  prdata = {16'b0, txy_ff};
         pprd_pkg::REG_TZD:  prdata = {8'b0, tzd_ff};
         pprd_pkg::REG_INTR: prdata = intr_ff;
         default:            prdata = '0;
      endcase
   end

   // field decode
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rot_c[i][j] = rot_ff[i][18*j +: 18];
         end
      end
      t_c[0] = txy_ff[23:0];
      t_c[1] = txy_ff[47:24];
      t_c[2] = tzd_ff[23:0];
      k1_c   = tzd_ff[39:24];
      k2_c   = tzd_ff[55:40];
      f_c[0] = intr_ff[15:0];
      f_c[1] = intr_ff[31:16];
      c_c[0] = intr_ff[47:32];
      c_c[1] = intr_ff[63:48];
      w_c[0] = req_world_x;
      w_c[1] = req_world_y;
      w_c[2] = req_world_z;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[pprd_pkg::PIPE_DEPTH-2:0], accept};
      end
   end

   // rotation products, partial sums, camera coordinates
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= rot_c[i][j] * w_c[j];
         end
         sa_ff[i] <= 44'(prod_ff[i][0]) + 44'(prod_ff[i][1]);
         sb_ff[i] <= 44'(prod_ff[i][2]) + $signed({{4{t_c[i][23]}}, t_c[i], 16'b0});
         pc_ff[i] <= sa_ff[i] + sb_ff[i];
      end
   end

   // magnitudes and rounded numerators for the depth divide
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = pc_ff[l][43] ? 44'(-pc_ff[l]) : 44'(pc_ff[l]);
         num_in[l] = 61'({mag_in[l], 16'b0}) + 61'(pc_ff[2][42:1]);
      end
   end

   always_ff @(posedge clock) begin
      den4_ff <= pc_ff[2][42:0];
      ok4_ff  <= pc_ff[2] > 44'sd0;
      for (int l = 0; l < 2; l++) begin
         num_ff[l] <= num_in[l];
         sg4_ff[l] <= pc_ff[l][43];
      end
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      logic [66:0] sh;
      sh = '0;
      for (int l = 0; l < 2; l++) begin
         rem_in[l][0] = num_ff[l];
         q_in[l][0]   = '0;
         for (int s = 0; s < pprd_pkg::DIV_STEPS; s++) begin
            sh = 67'(dd_ff[s]) << (pprd_pkg::DIV_STEPS - 1 - s);
            if (67'(rem_ff[l][s]) >= sh) begin
               rem_in[l][s+1] = 61'(67'(rem_ff[l][s]) - sh);
               q_in[l][s+1]   = q_ff[l][s] | (24'd1 << (pprd_pkg::DIV_STEPS - 1 - s));
            end else begin
               rem_in[l][s+1] = rem_ff[l][s];
               q_in[l][s+1]   = q_ff[l][s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dd_ff[0]  <= den4_ff;
      okd_ff[0] <= ok4_ff;
      for (int l = 0; l < 2; l++) begin
         rem_ff[l][0] <= rem_in[l][0];
         q_ff[l][0]   <= q_in[l][0];
         sat_ff[l][0] <= 67'(num_ff[l]) >= {den4_ff, 24'b0};
         sgd_ff[l][0] <= sg4_ff[l];
      end
      for (int s = 0; s < pprd_pkg::DIV_STEPS; s++) begin
         dd_ff[s+1]  <= dd_ff[s];
         okd_ff[s+1] <= okd_ff[s];
         for (int l = 0; l < 2; l++) begin
            rem_ff[l][s+1] <= rem_in[l][s+1];
            q_ff[l][s+1]   <= q_in[l][s+1];
            sat_ff[l][s+1] <= sat_ff[l][s];
            sgd_ff[l][s+1] <= sgd_ff[l][s];
         end
      end
   end

   // saturated normalised coordinates
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         xm_in[l] = sat_ff[l][pprd_pkg::DIV_STEPS] ? pprd_pkg::NORM_LIMIT
                                                    : q_ff[l][pprd_pkg::DIV_STEPS];
      end
   end

   // r^2, r^4 and the radial factor
   always_comb begin
      r2sum = 49'(sq_ff[0]) + 49'(sq_ff[1]) + 49'd32768;
      r2sq  = r2_ff * r2_ff;
      csum  = 51'sd1073741824 + 51'(k1r2b_ff) + 51'(k2r4_ff);
      cmag  = csum[50] ? 51'(-csum) : 51'(csum);
   end

   always_ff @(posedge clock) begin
      okm_ff[0] <= okd_ff[pprd_pkg::DIV_STEPS];
      for (int m = 1; m < 8; m++) begin
         okm_ff[m] <= okm_ff[m-1];
      end
      for (int l = 0; l < 2; l++) begin
         xmm_ff[l][0] <= xm_in[l];
         sgm_ff[l][0] <= sgd_ff[l][pprd_pkg::DIV_STEPS];
         sq_ff[l]     <= xm_in[l] * xm_in[l];
         for (int m = 1; m < 5; m++) begin
            xmm_ff[l][m] <= xmm_ff[l][m-1];
            sgm_ff[l][m] <= sgm_ff[l][m-1];
         end
      end
      r2_ff    <= (r2sum[48:16] > 33'(pprd_pkg::NORM_LIMIT)) ? pprd_pkg::NORM_LIMIT
                                                             : r2sum[39:16];
      r4_ff    <= 32'((r2sq + 48'd32768) >> 16);
      k1r2_ff  <= k1_c * $signed({1'b0, r2_ff});
      k2r4_ff  <= k2_c * $signed({1'b0, r4_ff});
      k1r2b_ff <= k1r2_ff;
      cm_ff    <= 36'((cmag + 51'd8192) >> 14);
      csg_ff   <= csum[50];
   end

   // distorted coordinate, focal scale, offset and clamp to the pixel range
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         dsum[l] = 61'(pl_ff[l]) + (61'(ph_ff[l]) << 18) + 61'd32768;
         pm[l]   = 45'((fp_ff[l] + 61'd32768) >> 16);
         ps[l]   = dsg_ff[l][2] ? -$signed({2'b0, pm[l]}) : $signed({2'b0, pm[l]});
         ps[l]   = ps[l] + $signed({31'b0, c_c[l]});
         if (ps[l] > pprd_pkg::PIX_MAX) begin
            pcl[l] = pprd_pkg::PIX_MAX;
         end else if (ps[l] < pprd_pkg::PIX_MIN) begin
            pcl[l] = pprd_pkg::PIX_MIN;
         end else begin
            pcl[l] = ps[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         pl_ff[l]     <= xmm_ff[l][4] * cm_ff[17:0];
         ph_ff[l]     <= xmm_ff[l][4] * cm_ff[35:18];
         dsg_ff[l][0] <= sgm_ff[l][4] ^ csg_ff;
         dsg_ff[l][1] <= dsg_ff[l][0];
         dsg_ff[l][2] <= dsg_ff[l][1];
         dm_ff[l]     <= dsum[l][60:16];
         fp_ff[l]     <= dm_ff[l] * f_c[l];
         pix_ff[l]    <= okm_ff[7] ? 19'(pcl[l]) : 19'sd0;
      end
   end

   // result strobe and validity
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_res_ff <= 1'b0;
      end else begin
         valid_res_ff <= vld_ff[pprd_pkg::PIPE_DEPTH-2] & okm_ff[7];
      end
   end

   assign rsp_strobe    = vld_ff[pprd_pkg::PIPE_DEPTH-1];
   assign rsp_pixel_u   = pix_ff[0];
   assign rsp_pixel_v   = pix_ff[1];
   assign rsp_valid_res = valid_res_ff;

   // every accepted request is followed by its result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(pprd_pkg::PIPE_DEPTH) rsp_strobe)
      else $error("accepted request without result strobe");

   // no result strobe without a matching request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, pprd_pkg::PIPE_DEPTH))
      else $error("result strobe without accepted request");

   // a point not in front of the camera reports zero pixels
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> (rsp_pixel_u == 19'sd0 && rsp_pixel_v == 19'sd0))
      else $error("invalid result with non-zero pixels");

   // valid flag only alongside a strobe
   a_valid_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_res |-> rsp_strobe)
      else $error("valid flag without result strobe");

   // divider remainder ends below the divisor when not saturated
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[28] && okd_ff[pprd_pkg::DIV_STEPS] && !sat_ff[0][pprd_pkg::DIV_STEPS])
      |-> (rem_ff[0][pprd_pkg::DIV_STEPS] < 61'(dd_ff[pprd_pkg::DIV_STEPS])))
      else $error("divider remainder not below divisor");

endmodule
